[rtl/c3rb_pkg.sv]
// shared types, constants and helpers for the 3x3 clamp-to-edge convolution
package c3rb_pkg;

    localparam int KSIZE       = 3;
    localparam int COEF_W      = 16;
    localparam int IN_PIX_W    = 16;
    localparam int OUT_W       = 36;
    localparam int IDX_W       = 10;
    localparam int DIM_W       = 11;
    localparam int KROW_W      = 48;
    localparam int CFG_IDX_W   = 3;
    localparam int FIFO_DEPTH  = 8;
    localparam int FIFO_PTR_W  = 3;
    localparam int FIFO_CNT_W  = 4;

    localparam logic [DIM_W-1:0]  DIM_RESET      = 11'd1024;
    localparam logic [KROW_W-1:0] KROW_TOP_RESET = 48'h0;
    localparam logic [KROW_W-1:0] KROW_MID_RESET = 48'h10000;
    localparam logic [KROW_W-1:0] KROW_BOT_RESET = 48'h0;

    typedef enum logic {
        CMD_PIXEL = 1'b0,
        CMD_FLUSH = 1'b1
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_WIDTH  = 3'd0,
        CFG_IMAGE_HEIGHT = 3'd1,
        CFG_KROW_TOP     = 3'd2,
        CFG_KROW_MID     = 3'd3,
        CFG_KROW_BOT     = 3'd4
    } t_cfg_reg;

    // one spare bit so a sum of two coefficients still fits
    typedef logic signed [COEF_W:0] t_coef;
    typedef t_coef [KSIZE-1:0] t_coef_col;

    typedef struct packed {
        logic load;
        logic fill;
    } t_cell_ctrl;

    typedef struct packed {
        logic rd_en;
        logic prev_wr_en;
        logic before_wr_en;
    } t_lb_ctrl;

    typedef struct packed {
        logic             e1;
        logic             e2;
        logic             flast;
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
    } t_meta;

    // one queue entry: up to two results caused by one pixel beat
    typedef struct packed {
        logic                    e1;
        logic                    e2;
        logic                    flast;
        logic [IDX_W-1:0]        row;
        logic [IDX_W-1:0]        col;
        logic signed [OUT_W-1:0] val1;
        logic signed [OUT_W-1:0] val2;
    } t_res_pair;

    function automatic t_coef kcoef(logic [KROW_W-1:0] krow, int j);
        logic [COEF_W-1:0] b;
        b = krow[COEF_W*j +: COEF_W];
        return {b[COEF_W-1], b};
    endfunction

endpackage

[rtl/c3rb_if.sv]
// valid/ready channel interfaces: pixel input, configuration writes, results
interface c3rb_pix_if import c3rb_pkg::*; ();
    logic                valid;
    logic                ready;
    logic                command;
    logic [IN_PIX_W-1:0] pixel_value;

    modport source(output valid, command, pixel_value, input ready);
    modport sink(input valid, command, pixel_value, output ready);
endinterface

interface c3rb_cfg_if import c3rb_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] reg_index;
    logic [KROW_W-1:0]    wr_data;

    modport source(output valid, reg_index, wr_data, input ready);
    modport sink(input valid, reg_index, wr_data, output ready);
endinterface

interface c3rb_res_if import c3rb_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [OUT_W-1:0] out_value;
    logic [IDX_W-1:0]        out_row;
    logic [IDX_W-1:0]        out_col;
    logic                    row_last;
    logic                    frame_last;

    modport source(output valid, out_value, out_row, out_col, row_last, frame_last,
                   input ready);
    modport sink(input valid, out_value, out_row, out_col, row_last, frame_last,
                 output ready);
endinterface

[rtl/c3rb_cell.sv]
// window column cell: holds one column of the 3x3 window, multiplies and sums it
module c3rb_cell import c3rb_pkg::*; #(
    parameter int PIX_W = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  t_cell_ctrl                    i_ctrl,
    input  logic [KSIZE-1:0][PIX_W-1:0]   i_shift_col,
    input  logic [KSIZE-1:0][PIX_W-1:0]   i_fill_col,
    input  t_coef_col                     i_p_coef,
    input  t_coef_col                     i_q_coef,
    output logic [KSIZE-1:0][PIX_W-1:0]   o_col,
    output logic signed [OUT_W-1:0]       o_p_dot,
    output logic signed [OUT_W-1:0]       o_q_dot
);

    localparam int PROD_W = PIX_W + COEF_W + 2;

    logic [KSIZE-1:0][PIX_W-1:0] r_col;
    logic signed [PIX_W:0]       px [KSIZE];
    logic signed [PROD_W-1:0]    r_pp [KSIZE];
    logic signed [PROD_W-1:0]    r_qp [KSIZE];
    logic signed [OUT_W-1:0]     r_p_dot;
    logic signed [OUT_W-1:0]     r_q_dot;

    // a row start loads the same column into every cell
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
        end else if (i_ctrl.load) begin
            r_col <= i_ctrl.fill ? i_fill_col : i_shift_col;
        end
    end

    always_comb begin
        for (int i = 0; i < KSIZE; i++) begin
            px[i] = $signed({1'b0, r_col[i]});
        end
    end

    // p: own kernel column, q: kernel column used for the row-end result
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < KSIZE; i++) begin
            r_pp[i] <= px[i] * $signed(i_p_coef[i]);
            r_qp[i] <= px[i] * $signed(i_q_coef[i]);
        end
        r_p_dot <= OUT_W'(r_pp[0]) + OUT_W'(r_pp[1]) + OUT_W'(r_pp[2]);
        r_q_dot <= OUT_W'(r_qp[0]) + OUT_W'(r_qp[1]) + OUT_W'(r_qp[2]);
    end

    assign o_col   = r_col;
    assign o_p_dot = r_p_dot;
    assign o_q_dot = r_q_dot;

endmodule

[rtl/c3rb_linebuf.sv]
// two line buffers with registered reads and a bypass for same-address reuse
module c3rb_linebuf import c3rb_pkg::*; #(
    parameter int PIX_W = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  t_lb_ctrl                 i_ctrl,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    input  logic [PIX_W-1:0]         i_prev_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_before_wr_addr,
    input  logic [PIX_W-1:0]         i_before_wr_data,
    output logic [PIX_W-1:0]         o_prev,
    output logic [PIX_W-1:0]         o_before
);

    logic [PIX_W-1:0] r_prev_mem   [DEPTH];
    logic [PIX_W-1:0] r_before_mem [DEPTH];
    logic [PIX_W-1:0] r_prev_q;
    logic [PIX_W-1:0] r_before_q;
    logic             r_byp;
    logic [PIX_W-1:0] r_byp_data;

    // prev is written at the read address; the read returns the old entry
    always_ff @(posedge i_clk) begin
        if (i_ctrl.prev_wr_en) begin
            r_prev_mem[i_rd_addr] <= i_prev_wr_data;
        end
        if (i_ctrl.rd_en) begin
            r_prev_q <= r_prev_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.before_wr_en) begin
            r_before_mem[i_before_wr_addr] <= i_before_wr_data;
        end
        if (i_ctrl.rd_en) begin
            r_before_q <= r_before_mem[i_rd_addr];
            r_byp      <= i_ctrl.before_wr_en && (i_before_wr_addr == i_rd_addr);
            r_byp_data <= i_before_wr_data;
        end
    end

    assign o_prev   = r_prev_q;
    assign o_before = r_byp ? r_byp_data : r_before_q;

endmodule

[rtl/c3rb_fifo.sv]
// result queue: one entry per pixel beat that gives results, handed out as one or two result beats
module c3rb_fifo import c3rb_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  t_res_pair             i_entry,
    output logic [FIFO_CNT_W-1:0] o_count,
    c3rb_res_if.source            o_res
);

    t_res_pair               r_mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0]   r_wr_ptr;
    logic [FIFO_PTR_W-1:0]   r_rd_ptr;
    logic [FIFO_CNT_W-1:0]   r_count;
    logic                    r_second;
    t_res_pair               head;
    logic                    show2;
    logic                    beat;
    logic                    pop;

    always_comb begin
        head  = r_mem[r_rd_ptr];
        show2 = !head.e1 || r_second;
        beat  = o_res.valid && o_res.ready;
        pop   = beat && (show2 || !head.e2);

        o_res.valid      = r_count != '0;
        o_res.out_value  = show2 ? head.val2 : head.val1;
        o_res.out_row    = head.row;
        o_res.out_col    = show2 ? head.col : head.col - IDX_W'(1);
        o_res.row_last   = show2;
        o_res.frame_last = show2 && head.flast;
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
            r_second <= 1'b0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + FIFO_PTR_W'(1);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + FIFO_PTR_W'(1);
                r_second <= 1'b0;
            end else if (beat) begin
                r_second <= 1'b1;
            end
            case ({i_push, pop})
                2'b10:   r_count <= r_count + FIFO_CNT_W'(1);
                2'b01:   r_count <= r_count - FIFO_CNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    assign o_count = r_count;

endmodule

[rtl/conv3x3_replicate_border.sv]
// top level: streaming 3x3 convolution, clamp-to-edge borders, chain of column cells
//
//  channel  dir  handshake        payload
//  i_pix    in   valid/ready      command, pixel_value
//  i_cfg    in   valid/ready      reg_index, wr_data (ready always high)
//  o_res    out  valid/ready      out_value, out_row, out_col, row_last, frame_last
//
//  one pixel beat per clock while i_pix.ready is high; its results pass the
//  stage valids r_v1 to r_v5 and the result queue before o_res.valid rises
//  past row 0, a row's last pixel (width > 1) gives two result beats from one entry
//  i_pix.ready drops once queued entries plus beats in the 5 pipeline stages
//  reach 8, i.e. when o_res has been stalled for a while
//  synchronous reset clears geometry, kernel, position and stage valids;
//  the line buffers are not cleared and need no init pass
module conv3x3_replicate_border import c3rb_pkg::*; #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024,
    parameter int PIXEL_BITS = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    c3rb_pix_if.sink   i_pix,
    c3rb_cfg_if.sink   i_cfg,
    c3rb_res_if.source o_res
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int RW = $clog2(MAX_HEIGHT + 1);

    // configuration
    logic [DIM_W-1:0]  r_cfg_w;
    logic [DIM_W-1:0]  r_cfg_h;
    logic [KROW_W-1:0] r_krow [KSIZE];
    logic              cfg_beat;
    t_cfg_reg          cfg_idx;
    logic [WW-1:0]     w_eff;
    logic [RW-1:0]     h_eff;

    // position and input decode
    logic [RW-1:0]         r_row;
    logic [RW-1:0]         n_row;
    logic [RW-1:0]         cur_row;
    logic [CW-1:0]         r_col;
    logic [CW-1:0]         n_col;
    logic [CW-1:0]         cur_col;
    logic                  wrap;
    logic                  flush_row;
    logic                  is_flush;
    logic                  ignored;
    logic                  pix_beat;
    logic                  take;
    logic                  c_last;
    logic [PIXEL_BITS-1:0] pix;
    t_meta                 meta0;

    // stage 1: line buffer data back, window column formed
    logic                  r_v1;
    logic [PIXEL_BITS-1:0] r_s1_pix;
    logic [CW-1:0]         r_s1_addr;
    logic                  r_s1_flush;
    logic                  r_s1_fill;
    logic                  r_s1_top_before;
    t_meta                 r_m1;
    t_lb_ctrl              lb_ctrl;
    logic [PIXEL_BITS-1:0] lb_prev;
    logic [PIXEL_BITS-1:0] lb_before;
    logic [KSIZE-1:0][PIXEL_BITS-1:0] s1_col;

    // cells
    t_cell_ctrl                       cell_ctrl;
    logic [KSIZE-1:0][PIXEL_BITS-1:0] cell_col  [KSIZE];
    logic [KSIZE-1:0][PIXEL_BITS-1:0] shift_col [KSIZE];
    logic signed [OUT_W-1:0]          p_dot [KSIZE];
    logic signed [OUT_W-1:0]          q_dot [KSIZE];
    t_coef_col                        p_coef [KSIZE];
    t_coef_col                        q_coef [KSIZE];
    t_coef_col                        r_qcoef1;
    t_coef_col                        r_qcoef2;

    // later stages
    logic                    r_v2, r_v3, r_v4, r_v5;
    t_meta                   r_m2, r_m3, r_m4, r_m5;
    logic signed [OUT_W-1:0] r_sum1;
    logic signed [OUT_W-1:0] r_sum2;
    logic                    push;
    t_res_pair               entry;
    logic [FIFO_CNT_W-1:0]   fifo_count;
    logic [FIFO_CNT_W:0]     occ;

    // ---------------- configuration ----------------
    assign i_cfg.ready = 1'b1;
    assign cfg_beat    = i_cfg.valid && i_cfg.ready;
    assign cfg_idx     = t_cfg_reg'(i_cfg.reg_index);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w   <= DIM_RESET;
            r_cfg_h   <= DIM_RESET;
            r_krow[0] <= KROW_TOP_RESET;
            r_krow[1] <= KROW_MID_RESET;
            r_krow[2] <= KROW_BOT_RESET;
        end else if (cfg_beat) begin
            case (cfg_idx)
                CFG_IMAGE_WIDTH:  r_cfg_w   <= i_cfg.wr_data[DIM_W-1:0];
                CFG_IMAGE_HEIGHT: r_cfg_h   <= i_cfg.wr_data[DIM_W-1:0];
                CFG_KROW_TOP:     r_krow[0] <= i_cfg.wr_data;
                CFG_KROW_MID:     r_krow[1] <= i_cfg.wr_data;
                CFG_KROW_BOT:     r_krow[2] <= i_cfg.wr_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        if (r_cfg_w == '0) begin
            w_eff = WW'(1);
        end else if (32'(r_cfg_w) > MAX_WIDTH) begin
            w_eff = WW'(MAX_WIDTH);
        end else begin
            w_eff = WW'(r_cfg_w);
        end
        if (r_cfg_h == '0) begin
            h_eff = RW'(1);
        end else if (32'(r_cfg_h) > MAX_HEIGHT) begin
            h_eff = RW'(MAX_HEIGHT);
        end else begin
            h_eff = RW'(r_cfg_h);
        end
    end

    // kernel columns; cell 0 never feeds the row-end sum, cell 2 takes the middle
    // and right kernel columns summed there, as its pixel column serves twice
    always_comb begin
        for (int j = 0; j < KSIZE; j++) begin
            for (int i = 0; i < KSIZE; i++) begin
                p_coef[j][i] = kcoef(r_krow[i], j);
            end
        end
        q_coef[0] = '0;
        q_coef[1] = r_qcoef1;
        q_coef[2] = r_qcoef2;
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < KSIZE; i++) begin
            r_qcoef1[i] <= p_coef[0][i];
            r_qcoef2[i] <= p_coef[1][i] + p_coef[2][i];
        end
    end

    // ---------------- input decode ----------------
    always_comb begin
        pix       = i_pix.pixel_value[PIXEL_BITS-1:0];
        wrap      = (WW'(r_col) >= w_eff) || (r_row > h_eff);
        cur_row   = wrap ? '0 : r_row;
        cur_col   = wrap ? '0 : r_col;
        flush_row = cur_row == h_eff;
        is_flush  = i_pix.command == CMD_FLUSH;
        ignored   = is_flush != flush_row;
        pix_beat  = i_pix.valid && i_pix.ready;
        take      = pix_beat && !ignored;
        c_last    = (WW'(cur_col) + WW'(1)) == w_eff;

        n_row = cur_row;
        n_col = cur_col;
        if (!ignored) begin
            if (c_last) begin
                n_col = '0;
                n_row = flush_row ? '0 : cur_row + RW'(1);
            end else begin
                n_col = cur_col + CW'(1);
            end
        end

        meta0.e1    = (cur_row != '0) && (cur_col != '0);
        meta0.e2    = (cur_row != '0) && c_last;
        meta0.flast = flush_row;
        meta0.row   = IDX_W'(cur_row - RW'(1));
        meta0.col   = IDX_W'(cur_col);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
            r_col <= '0;
        end else if (cfg_beat && (cfg_idx == CFG_IMAGE_WIDTH ||
                                  cfg_idx == CFG_IMAGE_HEIGHT)) begin
            r_row <= '0;
            r_col <= '0;
        end else if (pix_beat) begin
            r_row <= n_row;
            r_col <= n_col;
        end
    end

    // stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            r_v1 <= take;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_s1_pix        <= pix;
            r_s1_addr       <= cur_col;
            r_s1_flush      <= is_flush;
            r_s1_fill       <= cur_col == '0;
            r_s1_top_before <= cur_row > RW'(1);
            r_m1            <= meta0;
        end
        r_m2 <= r_m1;
        r_m3 <= r_m2;
        r_m4 <= r_m3;
        r_m5 <= r_m4;
    end

    // ---------------- line buffers ----------------
    always_comb begin
        lb_ctrl.rd_en        = take;
        lb_ctrl.prev_wr_en   = take && !is_flush;
        lb_ctrl.before_wr_en = r_v1 && !r_s1_flush;
    end

    c3rb_linebuf #(
        .PIX_W (PIXEL_BITS),
        .DEPTH (MAX_WIDTH)
    ) u_linebuf (
        .i_clk            (i_clk),
        .i_ctrl           (lb_ctrl),
        .i_rd_addr        (cur_col),
        .i_prev_wr_data   (pix),
        .i_before_wr_addr (r_s1_addr),
        .i_before_wr_data (lb_prev),
        .o_prev           (lb_prev),
        .o_before         (lb_before)
    );

    // clamped column: rows r-2, r-1, r; bottom row repeats on the flush row
    always_comb begin
        s1_col[0] = r_s1_top_before ? lb_before : lb_prev;
        s1_col[1] = lb_prev;
        s1_col[2] = r_s1_flush ? lb_prev : r_s1_pix;
        cell_ctrl.load = r_v1;
        cell_ctrl.fill = r_s1_fill;
        shift_col[0] = cell_col[1];
        shift_col[1] = cell_col[2];
        shift_col[2] = s1_col;
    end

    // ---------------- cell chain ----------------
    for (genvar j = 0; j < KSIZE; j++) begin : g_cell
        c3rb_cell #(
            .PIX_W (PIXEL_BITS)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctrl      (cell_ctrl),
            .i_shift_col (shift_col[j]),
            .i_fill_col  (s1_col),
            .i_p_coef    (p_coef[j]),
            .i_q_coef    (q_coef[j]),
            .o_col       (cell_col[j]),
            .o_p_dot     (p_dot[j]),
            .o_q_dot     (q_dot[j])
        );
    end

    always_ff @(posedge i_clk) begin
        r_sum1 <= p_dot[0] + p_dot[1] + p_dot[2];
        r_sum2 <= q_dot[0] + q_dot[1] + q_dot[2];
    end

    // ---------------- result queue ----------------
    always_comb begin
        push        = r_v5 && (r_m5.e1 || r_m5.e2);
        entry.e1    = r_m5.e1;
        entry.e2    = r_m5.e2;
        entry.flast = r_m5.flast;
        entry.row   = r_m5.row;
        entry.col   = r_m5.col;
        entry.val1  = r_sum1;
        entry.val2  = r_sum2;
    end

    c3rb_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (entry),
        .o_count (fifo_count),
        .o_res   (o_res)
    );

    // every beat in flight holds a queue slot
    always_comb begin
        occ = (FIFO_CNT_W+1)'(fifo_count) + (FIFO_CNT_W+1)'(r_v1) +
              (FIFO_CNT_W+1)'(r_v2) + (FIFO_CNT_W+1)'(r_v3) +
              (FIFO_CNT_W+1)'(r_v4) + (FIFO_CNT_W+1)'(r_v5);
        i_pix.ready = occ < (FIFO_CNT_W+1)'(FIFO_DEPTH);
    end

    // ---------------- assertions ----------------
    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fifo_count <= FIFO_CNT_W'(FIFO_DEPTH))
        else $error("result queue overfilled");

    a_pipe_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v1 |-> ##4 r_v5)
        else $error("pixel beat lost in the cell pipeline");

    a_ignore: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pix_beat && ignored) |=> !r_v1)
        else $error("ignored beat entered the pipeline");

    a_frame_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.frame_last) |-> o_res.row_last)
        else $error("frame end flagged away from a row end");

endmodule

[dv/tb_conv3x3_replicate_border.sv]
// self-checking testbench for the 3x3 clamp-to-edge convolution: random frames, stalls, scoreboard
module tb_conv3x3_replicate_border;
    import c3rb_pkg::*;

    localparam int MAX_W         = 1024;
    localparam int MAX_H         = 1024;
    localparam int RANDOM_BEATS  = 1040;
    localparam int SETTLE_CYCLES = 16;
    localparam int HOLD_CYCLES   = 300;

    typedef struct packed {
        t_cmd                cmd;
        logic [IN_PIX_W-1:0] value;
    } t_pix_beat;

    typedef struct packed {
        logic signed [OUT_W-1:0] value;
        logic [IDX_W-1:0]        row;
        logic [IDX_W-1:0]        col;
        logic                    row_last;
        logic                    frame_last;
    } t_conv_result;

    logic clk;
    logic rst_n;

    c3rb_pix_if pix();
    c3rb_cfg_if cfg();
    c3rb_res_if res();

    conv3x3_replicate_border uut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_pix   (pix),
        .i_cfg   (cfg),
        .o_res   (res)
    );

    // shadow of the block: registers, line buffers, window, position
    logic [DIM_W-1:0]    width_reg;
    logic [DIM_W-1:0]    height_reg;
    logic [KROW_W-1:0]   kernel_rows [KSIZE];
    logic [IN_PIX_W-1:0] line_above [MAX_W];
    logic [IN_PIX_W-1:0] line_two_above [MAX_W];
    logic [IN_PIX_W-1:0] window [KSIZE*KSIZE];
    int                  row_at;
    int                  col_at;

    t_pix_beat    pending_pixels[$];
    t_conv_result pending_results[$];

    int   mismatch_count = 0;
    int   send_idle_pct;
    int   recv_stall_pct;
    int   hold_left = 0;
    logic hold_req = 1'b0;
    logic hold_done = 1'b0;
    logic pix_taken;

    function automatic int clamp_dim(logic [DIM_W-1:0] v, int maxv);
        if (v == 0) return 1;
        if (v > maxv) return maxv;
        return int'(v);
    endfunction

    function automatic void window_shift(logic [IN_PIX_W-1:0] top, logic [IN_PIX_W-1:0] mid,
                                         logic [IN_PIX_W-1:0] bot);
        for (int i = 0; i < KSIZE; i++) begin
            window[i*KSIZE]   = window[i*KSIZE+1];
            window[i*KSIZE+1] = window[i*KSIZE+2];
        end
        window[2] = top;
        window[5] = mid;
        window[8] = bot;
    endfunction

    function automatic t_conv_result window_result(int r, int c, int w, int h);
        t_conv_result item;
        longint acc;
        longint pix_v;
        longint coef;
        acc = 0;
        for (int i = 0; i < KSIZE; i++) begin
            for (int j = 0; j < KSIZE; j++) begin
                pix_v = longint'(window[i*KSIZE+j]);
                coef  = longint'($signed(kernel_rows[i][COEF_W*j +: COEF_W]));
                acc  += pix_v * coef;
            end
        end
        item.value      = acc[OUT_W-1:0];
        item.row        = IDX_W'(r);
        item.col        = IDX_W'(c);
        item.row_last   = (c == w - 1);
        item.frame_last = (c == w - 1) && (r == h - 1);
        return item;
    endfunction

    // one accepted beat: update the shadow and queue the results it gives
    task automatic predict_conv_beat(t_cmd cmd, logic [IN_PIX_W-1:0] value);
        int w;
        int h;
        int r;
        int c;
        logic flush;
        logic [IN_PIX_W-1:0] above;
        logic [IN_PIX_W-1:0] two_above;
        logic [IN_PIX_W-1:0] top;
        logic [IN_PIX_W-1:0] bot;
        w = clamp_dim(width_reg, MAX_W);
        h = clamp_dim(height_reg, MAX_H);
        if (col_at >= w || row_at > h) begin
            row_at = 0;
            col_at = 0;
        end
        r = row_at;
        c = col_at;
        flush = (cmd == CMD_FLUSH);
        // flush outside the flush row, or pixel inside it: dropped
        if (flush != (r == h)) return;
        above     = line_above[c];
        two_above = line_two_above[c];
        top = (r >= 2) ? two_above : above;
        bot = flush ? above : value;
        if (!flush) begin
            line_two_above[c] = above;
            line_above[c]     = value;
        end
        if (c == 0) begin
            window_shift(top, above, bot);
            window_shift(top, above, bot);
        end
        window_shift(top, above, bot);
        if (r >= 1) begin
            if (c >= 1) begin
                pending_results.insert(pending_results.size(),
                                       window_result(r - 1, c - 1, w, h));
            end
            if (c == w - 1) begin
                // right edge column used again
                window_shift(top, above, bot);
                pending_results.insert(pending_results.size(), window_result(r - 1, c, w, h));
            end
        end
        c++;
        if (c >= w) begin
            c = 0;
            r++;
            if (r > h) r = 0;
        end
        row_at = r;
        col_at = c;
    endtask

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial begin
        #2000000;
        $display("TEST FAILED");
        $finish;
    end

    // scoreboard: register writes, accepted pixel beats, result beats
    always @(posedge clk) begin : monitor
        t_conv_result want;
        if (!rst_n) begin
            width_reg      = DIM_RESET;
            height_reg     = DIM_RESET;
            kernel_rows[0] = KROW_TOP_RESET;
            kernel_rows[1] = KROW_MID_RESET;
            kernel_rows[2] = KROW_BOT_RESET;
            foreach (line_above[k]) begin
                line_above[k]     = '0;
                line_two_above[k] = '0;
            end
            foreach (window[k]) window[k] = '0;
            row_at    = 0;
            col_at    = 0;
            pix_taken = 1'b0;
        end else begin
            pix_taken = pix.valid && pix.ready;
            if (cfg.valid && cfg.ready) begin
                case (t_cfg_reg'(cfg.reg_index))
                    CFG_IMAGE_WIDTH: begin
                        width_reg = cfg.wr_data[DIM_W-1:0];
                        row_at    = 0;
                        col_at    = 0;
                    end
                    CFG_IMAGE_HEIGHT: begin
                        height_reg = cfg.wr_data[DIM_W-1:0];
                        row_at     = 0;
                        col_at     = 0;
                    end
                    CFG_KROW_TOP: kernel_rows[0] = cfg.wr_data;
                    CFG_KROW_MID: kernel_rows[1] = cfg.wr_data;
                    CFG_KROW_BOT: kernel_rows[2] = cfg.wr_data;
                    default: ;
                endcase
            end
            if (pix_taken) predict_conv_beat(t_cmd'(pix.command), pix.pixel_value);
            if (res.valid && res.ready) begin
                if (pending_results.size() == 0) begin
                    $error("unexpected result beat: row %0d col %0d value %0d",
                           res.out_row, res.out_col, res.out_value);
                    mismatch_count++;
                end else begin
                    want = pending_results.pop_front();
                    if (res.out_value !== want.value) begin
                        $error("out_value mismatch: expected %0d, got %0d",
                               $signed(want.value), res.out_value);
                        mismatch_count++;
                    end
                    if (res.out_row !== want.row) begin
                        $error("out_row mismatch: expected %0d, got %0d", want.row, res.out_row);
                        mismatch_count++;
                    end
                    if (res.out_col !== want.col) begin
                        $error("out_col mismatch: expected %0d, got %0d", want.col, res.out_col);
                        mismatch_count++;
                    end
                    if (res.row_last !== want.row_last) begin
                        $error("row_last mismatch: expected %0b, got %0b",
                               want.row_last, res.row_last);
                        mismatch_count++;
                    end
                    if (res.frame_last !== want.frame_last) begin
                        $error("frame_last mismatch: expected %0b, got %0b",
                               want.frame_last, res.frame_last);
                        mismatch_count++;
                    end
                end
            end
        end
    end

    // pixel driver
    always @(negedge clk) begin : pixel_driver
        t_pix_beat next_beat;
        if (!rst_n) begin
            pix.valid <= 1'b0;
        end else if (!pix.valid || pix_taken) begin
            if (pending_pixels.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                next_beat = pending_pixels.pop_front();
                pix.valid       <= 1'b1;
                pix.command     <= next_beat.cmd;
                pix.pixel_value <= next_beat.value;
            end else begin
                pix.valid       <= 1'b0;
                pix.command     <= 1'($urandom_range(1));
                pix.pixel_value <= IN_PIX_W'($urandom);
            end
        end
    end

    // result receiver, with one long hold-off on request
    always @(negedge clk) begin
        if (!rst_n) begin
            res.ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            res.ready <= 1'b0;
        end else if (hold_req && !hold_done) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            res.ready <= 1'b0;
        end else begin
            res.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    function automatic void push_beat(t_cmd cmd, logic [IN_PIX_W-1:0] value);
        t_pix_beat b;
        b.cmd   = cmd;
        b.value = value;
        pending_pixels.insert(pending_pixels.size(), b);
    endfunction

    function automatic logic [IN_PIX_W-1:0] rand_pixel();
        case ($urandom_range(7))
            0: return '0;
            1: return '1;
            default: return IN_PIX_W'($urandom);
        endcase
    endfunction

    function automatic logic [KROW_W-1:0] rand_krow();
        logic [KROW_W-1:0] k;
        for (int j = 0; j < KSIZE; j++) begin
            case ($urandom_range(5))
                0: k[COEF_W*j +: COEF_W] = 16'h8000;
                1: k[COEF_W*j +: COEF_W] = 16'h7FFF;
                2: k[COEF_W*j +: COEF_W] = 16'h0000;
                3: k[COEF_W*j +: COEF_W] = 16'($urandom_range(8)) - 16'd4;
                default: k[COEF_W*j +: COEF_W] = 16'($urandom);
            endcase
        end
        return k;
    endfunction

    // whole frame plus its flush row, with stray beats of the wrong kind mixed in
    task automatic queue_frame(int w, int h, int noise_pct);
        for (int r = 0; r <= h; r++) begin
            for (int c = 0; c < w; c++) begin
                if ($urandom_range(99) < noise_pct)
                    push_beat(r == h ? CMD_PIXEL : CMD_FLUSH, rand_pixel());
                push_beat(r == h ? CMD_FLUSH : CMD_PIXEL, rand_pixel());
            end
        end
    endtask

    task automatic write_reg(t_cfg_reg idx, logic [KROW_W-1:0] data);
        @(negedge clk);
        cfg.valid     = 1'b1;
        cfg.reg_index = idx;
        cfg.wr_data   = data;
        do @(posedge clk); while (!cfg.ready);
        @(negedge clk);
        cfg.valid = 1'b0;
    endtask

    // beats that give no result may still be in the pipe when the last result leaves
    task automatic wait_block_idle();
        while (pending_pixels.size() != 0 || pix.valid || pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial begin : stimulus
        logic [DIM_W-1:0]  w_raw;
        logic [DIM_W-1:0]  h_raw;
        logic [KROW_W-1:0] junk;
        int w_eff;
        int h_eff;
        int beats_sent;
        int cut;
        cfg.valid       = 1'b0;
        cfg.reg_index   = CFG_IMAGE_WIDTH;
        cfg.wr_data     = '0;
        send_idle_pct   = 11;
        recv_stall_pct  = 70;
        rst_n           = 1'b0;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;

        // corner pixels and coefficients; stray flush in row 0, stray pixel in the flush row
        write_reg(CFG_IMAGE_WIDTH, 48'd4);
        write_reg(CFG_IMAGE_HEIGHT, 48'd2);
        write_reg(CFG_KROW_TOP, 48'hFFFF_7FFF_8000);
        write_reg(CFG_KROW_MID, 48'h0001_8000_7FFF);
        write_reg(CFG_KROW_BOT, 48'h7FFF_0000_8000);
        push_beat(CMD_FLUSH, 16'hFFFF);
        push_beat(CMD_PIXEL, 16'hFFFF);
        push_beat(CMD_PIXEL, 16'h0000);
        push_beat(CMD_PIXEL, 16'hFFFF);
        push_beat(CMD_PIXEL, 16'h0000);
        push_beat(CMD_PIXEL, 16'h0000);
        push_beat(CMD_PIXEL, 16'hFFFF);
        push_beat(CMD_PIXEL, 16'h0001);
        push_beat(CMD_PIXEL, 16'h8000);
        push_beat(CMD_FLUSH, 16'h0000);
        push_beat(CMD_FLUSH, 16'h5A5A);
        push_beat(CMD_PIXEL, 16'h1234);
        push_beat(CMD_FLUSH, 16'hFFFF);
        push_beat(CMD_FLUSH, 16'h0000);
        wait_block_idle();

        // zero geometry acts as 1x1; most negative sum
        write_reg(CFG_IMAGE_WIDTH, 48'd0);
        write_reg(CFG_IMAGE_HEIGHT, 48'd0);
        write_reg(CFG_KROW_TOP, 48'h8000_8000_8000);
        write_reg(CFG_KROW_MID, 48'h8000_8000_8000);
        write_reg(CFG_KROW_BOT, 48'h8000_8000_8000);
        push_beat(CMD_PIXEL, 16'hFFFF);
        push_beat(CMD_FLUSH, 16'h0000);
        wait_block_idle();

        // abandoned frame restarted by a geometry write; most positive sum
        write_reg(CFG_IMAGE_WIDTH, 48'd3);
        write_reg(CFG_IMAGE_HEIGHT, 48'd1);
        write_reg(CFG_KROW_TOP, 48'h7FFF_7FFF_7FFF);
        write_reg(CFG_KROW_MID, 48'h7FFF_7FFF_7FFF);
        write_reg(CFG_KROW_BOT, 48'h7FFF_7FFF_7FFF);
        push_beat(CMD_PIXEL, 16'h0000);
        push_beat(CMD_PIXEL, 16'h0000);
        wait_block_idle();
        write_reg(CFG_IMAGE_WIDTH, 48'd3);
        repeat (3) push_beat(CMD_PIXEL, 16'hFFFF);
        repeat (3) push_beat(CMD_FLUSH, 16'hFFFF);
        wait_block_idle();

        beats_sent = 0;
        while (beats_sent < RANDOM_BEATS) begin
            if (beats_sent < RANDOM_BEATS / 3) begin
                send_idle_pct  = 11;
                recv_stall_pct = 70;
            end else if (beats_sent < 2 * RANDOM_BEATS / 3) begin
                send_idle_pct  = 70;
                recv_stall_pct = 11;
            end else begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            case ($urandom_range(9))
                0: w_raw = '0;
                1: w_raw = DIM_W'($urandom_range(13, 40));
                default: w_raw = DIM_W'($urandom_range(1, 12));
            endcase
            h_raw = DIM_W'($urandom_range(0, 8));
            w_eff = clamp_dim(w_raw, MAX_W);
            h_eff = clamp_dim(h_raw, MAX_H);
            // unused upper bits of geometry writes carry junk
            junk = KROW_W'({$urandom, $urandom});
            write_reg(CFG_IMAGE_WIDTH, {junk[KROW_W-1:DIM_W], w_raw});
            junk = KROW_W'({$urandom, $urandom});
            write_reg(CFG_IMAGE_HEIGHT, {junk[KROW_W-1:DIM_W], h_raw});
            if ($urandom_range(1)) write_reg(CFG_KROW_TOP, rand_krow());
            if ($urandom_range(1)) write_reg(CFG_KROW_MID, rand_krow());
            if ($urandom_range(1)) write_reg(CFG_KROW_BOT, rand_krow());
            repeat ($urandom_range(1, 3)) begin
                queue_frame(w_eff, h_eff, 5);
                beats_sent += w_eff * (h_eff + 1);
            end
            if ($urandom_range(5) == 0) begin
                // frame cut off anywhere; the next geometry write starts over
                cut = $urandom_range(1, w_eff * (h_eff + 1));
                for (int k = 0; k < cut; k++)
                    push_beat(k >= w_eff * h_eff ? CMD_FLUSH : CMD_PIXEL, rand_pixel());
                beats_sent += cut;
            end
            wait_block_idle();
        end

        // full-rate frame; receiver holds off so the pipe backs up into the input
        write_reg(CFG_IMAGE_WIDTH, 48'd12);
        write_reg(CFG_IMAGE_HEIGHT, 48'd6);
        write_reg(CFG_KROW_TOP, rand_krow());
        write_reg(CFG_KROW_MID, rand_krow());
        write_reg(CFG_KROW_BOT, rand_krow());
        queue_frame(12, 6, 2);
        @(posedge clk);
        hold_req = 1'b1;
        wait_block_idle();

        if (mismatch_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

[conv3x3_replicate_border.f]
rtl/c3rb_pkg.sv
rtl/c3rb_if.sv
rtl/c3rb_cell.sv
rtl/c3rb_linebuf.sv
rtl/c3rb_fifo.sv
rtl/conv3x3_replicate_border.sv
dv/tb_conv3x3_replicate_border.sv
